// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

   // default sizes of the store
   localparam int SPQ_CAPACITY = 16;
   localparam int SPQ_KEY_W    = 32;
   localparam int SPQ_DATA_W   = 32;

   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_POP_HEAD = 2'd1,
      CMD_POP_TAIL = 2'd2,
      CMD_PEEK     = 2'd3
   } spq_cmd_type;

   // insert placement; the unused code acts as sorted
   localparam logic [1:0] MODE_SORTED = 2'd0;
   localparam logic [1:0] MODE_STACK  = 2'd1;
   localparam logic [1:0] MODE_QUEUE  = 2'd2;

   typedef struct packed {
      logic       ins;
      logic       pop_head;
      logic [1:0] mode;
   } spq_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module spq_cell #(
   parameter int INDEX  = 0,
   parameter int KEY_W  = spq_pkg::SPQ_KEY_W,
   parameter int DATA_W = spq_pkg::SPQ_DATA_W,
   parameter int CNT_W  = 5
) (
   input  wire                      clock,
   input  spq_pkg::spq_ctl_type     ctl,
   input  wire  [CNT_W-1:0]         count,
   input  wire  signed [KEY_W-1:0]  new_key,
   input  wire  [DATA_W-1:0]        new_data,
   input  wire  signed [KEY_W-1:0]  left_key,
   input  wire  [DATA_W-1:0]        left_data,
   input  wire  signed [KEY_W-1:0]  right_key,
   input  wire  [DATA_W-1:0]        right_data,
   input  wire                      shift_in,
   output logic                     shift_out,
   output logic signed [KEY_W-1:0]  key,
   output logic [DATA_W-1:0]        data,
   output logic                     is_tail
);
   import spq_pkg::*;

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0]       data_ff, data_in;
   logic                    occupied;
   logic                    goes_here;

   assign occupied = count > CNT_W'(INDEX);
   assign is_tail  = count == CNT_W'(INDEX + 1);

   // first cell that claims the new entry marks the insert point
   always_comb begin
      unique case (ctl.mode)
         MODE_STACK: goes_here = 1'b1;
         MODE_QUEUE: goes_here = !occupied;
         default:    goes_here = !occupied || (new_key < key_ff);
      endcase
   end

   assign shift_out = shift_in || goes_here;

   always_comb begin
      key_in  = key_ff;
      data_in = data_ff;
      priority if (ctl.ins && shift_in) begin
         key_in  = left_key;
         data_in = left_data;
      end else if (ctl.ins && goes_here) begin
         key_in  = new_key;
         data_in = new_data;
      end else if (ctl.pop_head) begin
         key_in  = right_key;
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
   end

   assign key  = key_ff;
   assign data = data_ff;

endmodule
`default_nettype wire

// ----- rtl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// sorted double-ended priority queue built as a row of shifting cells
// commands: a transfer happens at a rising edge with start high and busy low;
//   req_command picks insert, remove head, remove tail or peek, and an insert
//   carries req_item_key (signed) and req_item_data
// placement of an insert follows queue_mode (register 0 on the apb port):
//   sorted (after all equal or smaller keys), stack (head) or queue (tail)
// every cell compares the new key in parallel and the whole row shifts together,
//   so busy stays low and a command is taken every cycle
// the result is shown in the cycle after the command transfer, for one
//   cycle, marked by rsp_strobe; it gives head and tail entries, count, empty,
//   full and a rejected flag (insert when full, removal when empty)
// throughput: one command per clock cycle, since busy is never raised
// the receiver cannot hold results off, so nothing is ever backed up
// reset (synchronous, active high) empties the store, clears the strobe and
//   returns queue_mode to sorted; cell contents are left as they are since the
//   count alone decides which cells are occupied
module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::SPQ_CAPACITY,
   parameter int KEY_W    = spq_pkg::SPQ_KEY_W,
   parameter int DATA_W   = spq_pkg::SPQ_DATA_W,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  wire                     clock,
   input  wire                     reset,
   // command channel
   input  wire                     start,
   output logic                    busy,
   input  wire  [1:0]              req_command,
   input  wire  signed [KEY_W-1:0] req_item_key,
   input  wire  [DATA_W-1:0]       req_item_data,
   // result channel
   output logic                    rsp_strobe,
   output logic signed [KEY_W-1:0] rsp_head_key,
   output logic [DATA_W-1:0]       rsp_head_data,
   output logic signed [KEY_W-1:0] rsp_tail_key,
   output logic [DATA_W-1:0]       rsp_tail_data,
   output logic [CNT_W-1:0]        rsp_entry_count,
   output logic                    rsp_is_empty,
   output logic                    rsp_is_full,
   output logic                    rsp_rejected,
   // register port
   input  wire                     psel,
   input  wire                     penable,
   input  wire                     pwrite,
   input  wire  [2:0]              paddr,
   input  wire  [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import spq_pkg::*;

   // register index from the byte address
   localparam logic REG_QUEUE_MODE = 1'b0;

   logic                    accept;
   logic                    full;
   logic                    empty;
   spq_ctl_type             ctl;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [1:0]              mode_ff, mode_in;
   logic                    strobe_ff;
   logic                    rejected_ff, rejected_in;

   logic signed [KEY_W-1:0] cell_key   [CAPACITY];
   logic [DATA_W-1:0]       cell_data  [CAPACITY];
   logic                    cell_tail  [CAPACITY];
   logic                    cell_shift [CAPACITY+1];

   logic signed [KEY_W-1:0] tail_key;
   logic [DATA_W-1:0]       tail_data;

   // the whole row shifts together, so a new command can follow at once
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign full  = count_ff == CNT_W'(CAPACITY);
   assign empty = count_ff == '0;

   // ------------------------------------------------------------------
   // register port: one register, written on the access phase
   // ------------------------------------------------------------------
   assign pready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && pready && paddr[2] == REG_QUEUE_MODE) begin
         mode_in = pwdata[1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_QUEUE_MODE) begin
         prdata = {30'd0, mode_ff};
      end
   end

   // ------------------------------------------------------------------
   // command decode and occupancy count
   // ------------------------------------------------------------------
   always_comb begin
      ctl.ins      = 1'b0;
      ctl.pop_head = 1'b0;
      ctl.mode     = mode_ff;
      count_in     = count_ff;
      rejected_in  = 1'b0;
      if (accept) begin
         unique case (spq_cmd_type'(req_command))
            CMD_INSERT: begin
               if (full) begin
                  rejected_in = 1'b1;
               end else begin
                  ctl.ins  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_POP_HEAD: begin
               if (empty) begin
                  rejected_in = 1'b1;
               end else begin
                  ctl.pop_head = 1'b1;
                  count_in     = count_ff - CNT_W'(1);
               end
            end
            CMD_POP_TAIL: begin
               // the last cell simply drops out of the occupied range
               if (empty) begin
                  rejected_in = 1'b1;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            CMD_PEEK: begin
               rejected_in = 1'b0;
            end
            default: begin
               rejected_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         mode_ff     <= MODE_SORTED;
         strobe_ff   <= 1'b0;
         rejected_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         mode_ff     <= mode_in;
         strobe_ff   <= accept;
         rejected_ff <= rejected_in;
      end
   end

   // ------------------------------------------------------------------
   // row of cells; the insert point ripples head to tail as shift_in
   // ------------------------------------------------------------------
   assign cell_shift[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] left_key;
      logic [DATA_W-1:0]       left_data;
      logic signed [KEY_W-1:0] right_key;
      logic [DATA_W-1:0]       right_data;

      if (i == 0) begin : g_first
         assign left_key  = req_item_key;
         assign left_data = req_item_data;
      end else begin : g_inner
         assign left_key  = cell_key[i-1];
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         // the last cell empties on a head removal, contents do not matter
         assign right_key  = req_item_key;
         assign right_data = req_item_data;
      end else begin : g_mid
         assign right_key  = cell_key[i+1];
         assign right_data = cell_data[i+1];
      end

      spq_cell #(
         .INDEX  (i),
         .KEY_W  (KEY_W),
         .DATA_W (DATA_W),
         .CNT_W  (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .new_key    (req_item_key),
         .new_data   (req_item_data),
         .left_key   (left_key),
         .left_data  (left_data),
         .right_key  (right_key),
         .right_data (right_data),
         .shift_in   (cell_shift[i]),
         .shift_out  (cell_shift[i+1]),
         .key        (cell_key[i]),
         .data       (cell_data[i]),
         .is_tail    (cell_tail[i])
      );
   end

   // ------------------------------------------------------------------
   // result: tail picked by and-or over the one-hot tail marks
   // ------------------------------------------------------------------
   always_comb begin
      tail_key  = '0;
      tail_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_key  = tail_key | (cell_key[i] & {KEY_W{cell_tail[i]}});
         tail_data = tail_data | (cell_data[i] & {DATA_W{cell_tail[i]}});
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_head_key    = empty ? '0 : cell_key[0];
   assign rsp_head_data   = empty ? '0 : cell_data[0];
   assign rsp_tail_key    = tail_key;
   assign rsp_tail_data   = tail_data;
   assign rsp_entry_count = count_ff;
   assign rsp_is_empty    = empty;
   assign rsp_is_full     = full;
   assign rsp_rejected    = rejected_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted command produced no result");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      accept && req_command == CMD_INSERT && full
      |=> rsp_rejected && $stable(count_ff))
      else $error("insert into full store not rejected");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_command == CMD_POP_HEAD && !empty
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("head removal did not lower the count");

   a_reject_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_rejected == $past(rejected_in))
      else $error("rejected flag lost between command and result");

   a_insert_slot: assert property (@(posedge clock) disable iff (reset)
      ctl.ins |-> cell_shift[CAPACITY])
      else $error("insert found no cell to claim it");

endmodule
`default_nettype wire
